[rtl/core/ps2md_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2md_pkg
// Shared types and constants for the four-byte PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package ps2md_pkg;

  localparam int POS_WIDTH_DEFAULT = 32;
  localparam int OUT_WIDTH         = 32;

  // Byte position within a packet
  localparam logic [1:0] IDX_STATUS = 2'd0;
  localparam logic [1:0] IDX_DX     = 2'd1;
  localparam logic [1:0] IDX_DY     = 2'd2;
  localparam logic [1:0] IDX_WHEEL  = 2'd3;

  localparam logic [7:0] OVF_MASK   = 8'hC0;
  localparam logic [3:0] WHEEL_UP   = 4'd1;
  localparam logic [3:0] WHEEL_DOWN = 4'd15;

  typedef struct packed {
    logic extra_two;
    logic extra_one;
    logic right;
    logic middle;
    logic left;
  } buttons_t;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] wheel;
  } packet_t;

endpackage : ps2md_pkg
`default_nettype wire

[rtl/core/ps2md_channels.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2md channels
// Valid/ready channel interfaces: received bytes in, decoded reports out.
// ----------------------------------------------------------------------------
interface ps2md_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       resync;

  modport source (output valid, output data_byte, output resync, input ready);
  modport sink   (input valid, input data_byte, input resync, output ready);
endinterface : ps2md_byte_if

interface ps2md_report_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] scroll_count;
  logic               left_pressed;
  logic               middle_pressed;
  logic               right_pressed;
  logic               extra_one_pressed;
  logic               extra_two_pressed;
  logic               packet_dropped;

  modport source (
    output valid, output pos_x, output pos_y, output scroll_count,
    output left_pressed, output middle_pressed, output right_pressed,
    output extra_one_pressed, output extra_two_pressed, output packet_dropped,
    input ready
  );
  modport sink (
    input valid, input pos_x, input pos_y, input scroll_count,
    input left_pressed, input middle_pressed, input right_pressed,
    input extra_one_pressed, input extra_two_pressed, input packet_dropped,
    output ready
  );
endinterface : ps2md_report_if
`default_nettype wire

[rtl/core/ps2md_accum.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2md_accum
// Packet update: next positions, wheel count and buttons from a full packet.
// ----------------------------------------------------------------------------
module ps2md_accum
  import ps2md_pkg::*;
#(
  parameter int POS_WIDTH = POS_WIDTH_DEFAULT
) (
  input  packet_t              pkt,
  input  logic [POS_WIDTH-1:0] pos_x,
  input  logic [POS_WIDTH-1:0] pos_y,
  input  logic [31:0]          wheel,
  input  buttons_t             buttons,
  output logic [POS_WIDTH-1:0] pos_x_next,
  output logic [POS_WIDTH-1:0] pos_y_next,
  output logic [31:0]          wheel_next,
  output buttons_t             buttons_next,
  output logic                 dropped
);

  logic [POS_WIDTH-1:0] delta_x;
  logic [POS_WIDTH-1:0] delta_y;
  buttons_t             decoded;

  // Sign bits of the deltas live in the status byte
  assign delta_x = {{(POS_WIDTH-8){pkt.status[4]}}, pkt.dx};
  assign delta_y = {{(POS_WIDTH-8){pkt.status[5]}}, pkt.dy};
  assign dropped = |(pkt.status & OVF_MASK);

  always_comb begin
    decoded.left      = pkt.status[0];
    decoded.right     = pkt.status[1];
    decoded.middle    = pkt.status[2];
    decoded.extra_one = pkt.wheel[4];
    decoded.extra_two = pkt.wheel[5];
  end

  always_comb begin
    pos_x_next   = pos_x;
    pos_y_next   = pos_y;
    wheel_next   = wheel;
    buttons_next = buttons;
    if (!dropped) begin
      pos_x_next   = pos_x + delta_x;
      pos_y_next   = pos_y + delta_y;
      buttons_next = decoded;
      case (pkt.wheel[3:0])
        WHEEL_DOWN: wheel_next = wheel - 32'd1;
        WHEEL_UP:   wheel_next = wheel + 32'd1;
        default:    wheel_next = wheel;
      endcase
    end
  end

endmodule : ps2md_accum
`default_nettype wire

[rtl/core/ps2_mouse_packet_decoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_unit
// Four-byte PS/2 wheel mouse packet decoder with position and scroll totals.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                       per transaction
//  rx_byte   in    data_byte[7:0], resync                        one mouse byte
//  report    out   pos_x, pos_y, scroll_count, 5 buttons, drop   one packet
//
//  One byte per cycle. The fourth byte of a packet updates the totals and
//  loads the report register at the same edge; the report shows next cycle.
//  rst clears the byte counter, totals, buttons and the report valid.
//  A stalled report blocks only a byte at packet position four, resync or not;
//  bytes one to three keep flowing.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder_unit
  import ps2md_pkg::*;
#(
  parameter int POS_WIDTH = POS_WIDTH_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  ps2md_byte_if.sink     rx_byte,
  ps2md_report_if.source report
);

  logic [1:0]           byte_index;
  logic [7:0]           first_byte;
  logic [7:0]           delta_x_byte;
  logic [7:0]           delta_y_byte;
  logic [POS_WIDTH-1:0] position_x;
  logic [POS_WIDTH-1:0] position_y;
  logic [31:0]          wheel_total;
  buttons_t             button_flags;

  logic [POS_WIDTH-1:0] position_x_next;
  logic [POS_WIDTH-1:0] position_y_next;
  logic [31:0]          wheel_total_next;
  buttons_t             button_flags_next;
  logic                 dropped;

  logic                 report_valid;
  logic [1:0]           idx;
  logic                 accept;
  packet_t              pkt;

  assign idx    = rx_byte.resync ? IDX_STATUS : byte_index;
  assign accept = rx_byte.valid && rx_byte.ready;

  // Hold off a packet-closing byte while the previous report is still pending
  assign rx_byte.ready = !(byte_index == IDX_WHEEL && report_valid && !report.ready);

  always_comb begin
    pkt.status = first_byte;
    pkt.dx     = delta_x_byte;
    pkt.dy     = delta_y_byte;
    pkt.wheel  = rx_byte.data_byte;
  end

  ps2md_accum #(
    .POS_WIDTH (POS_WIDTH)
  ) u_accum (
    .pkt          (pkt),
    .pos_x        (position_x),
    .pos_y        (position_y),
    .wheel        (wheel_total),
    .buttons      (button_flags),
    .pos_x_next   (position_x_next),
    .pos_y_next   (position_y_next),
    .wheel_next   (wheel_total_next),
    .buttons_next (button_flags_next),
    .dropped      (dropped)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= IDX_STATUS;
      first_byte   <= '0;
      delta_x_byte <= '0;
      delta_y_byte <= '0;
      position_x   <= '0;
      position_y   <= '0;
      wheel_total  <= '0;
      button_flags <= '0;
      report_valid <= 1'b0;
    end else begin
      // Load a new report or drop the one just taken
      if (accept && idx == IDX_WHEEL) begin
        report_valid <= 1'b1;
      end else if (report.ready) begin
        report_valid <= 1'b0;
      end
      if (accept) begin
        unique case (idx)
          IDX_STATUS: begin
            first_byte <= rx_byte.data_byte;
            byte_index <= IDX_DX;
          end
          IDX_DX: begin
            delta_x_byte <= rx_byte.data_byte;
            byte_index   <= IDX_DY;
          end
          IDX_DY: begin
            delta_y_byte <= rx_byte.data_byte;
            byte_index   <= IDX_WHEEL;
          end
          IDX_WHEEL: begin
            byte_index   <= IDX_STATUS;
            position_x   <= position_x_next;
            position_y   <= position_y_next;
            wheel_total  <= wheel_total_next;
            button_flags <= button_flags_next;
          end
          default: byte_index <= IDX_STATUS;
        endcase
      end
    end
  end

  // Report payload: loaded with the updated totals when a packet closes
  always_ff @(posedge clk) begin
    if (accept && idx == IDX_WHEEL) begin
      report.pos_x             <= OUT_WIDTH'($signed(position_x_next));
      report.pos_y             <= OUT_WIDTH'($signed(position_y_next));
      report.scroll_count      <= $signed(wheel_total_next);
      report.left_pressed      <= button_flags_next.left;
      report.middle_pressed    <= button_flags_next.middle;
      report.right_pressed     <= button_flags_next.right;
      report.extra_one_pressed <= button_flags_next.extra_one;
      report.extra_two_pressed <= button_flags_next.extra_two;
      report.packet_dropped    <= dropped;
    end
  end

  assign report.valid = report_valid;

endmodule : ps2_mouse_packet_decoder_unit
`default_nettype wire

[rtl/core/ps2md_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2md_checker
// Port-level checks for the PS/2 mouse packet decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ps2md_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         in_valid,
  input wire logic         in_ready,
  input wire logic         in_resync,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire logic [101:0] out_payload
);

  // A stalled report keeps its payload
  a_report_stable : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_payload))
    else $error("report payload changed while stalled");

  a_report_held : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("report valid dropped before transaction");

  a_reset_clears : assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("report valid after reset");

  // A new report only follows an accepted byte
  a_report_cause : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("report appeared without an input transaction");

  // A resync byte starts a packet and never closes one
  a_resync_no_report : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_resync && !out_valid) |=> !out_valid)
    else $error("report produced by a resync byte");

endmodule : ps2md_checker

bind ps2_mouse_packet_decoder_unit ps2md_checker u_ps2md_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (rx_byte.valid),
  .in_ready    (rx_byte.ready),
  .in_resync   (rx_byte.resync),
  .out_valid   (report.valid),
  .out_ready   (report.ready),
  .out_payload ({report.pos_x, report.pos_y, report.scroll_count,
                 report.left_pressed, report.middle_pressed, report.right_pressed,
                 report.extra_one_pressed, report.extra_two_pressed,
                 report.packet_dropped})
);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-byte PS/2 mouse packet decoder. A directed
// table covers reset, delta extremes, wheel codes, overflow and resync. Random
// packets follow, with broken packets, noise and random stalls on both sides.
// Directed reports are checked against the table, random ones against a local decoder model.
// ----------------------------------------------------------------------------
module testbench;
  import ps2md_pkg::*;

  localparam int POS_W          = POS_WIDTH_DEFAULT;
  localparam int RANDOM_BYTES   = 1000;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 8;
  localparam int LONG_HOLD      = 80;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] pos_x;
    logic signed [OUT_WIDTH-1:0] pos_y;
    logic signed [OUT_WIDTH-1:0] scroll;
    buttons_t                    buttons;
    logic                        dropped;
  } report_t;

  typedef struct {
    logic [7:0] data_byte;
    logic       resync;
    bit         typed;
    report_t    want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  always #2 clk = ~clk;

  ps2md_byte_if   rx_byte ();
  ps2md_report_if report ();

  ps2_mouse_packet_decoder_unit #(
    .POS_WIDTH(POS_W)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .rx_byte(rx_byte),
    .report (report)
  );

  // Decoder model state
  logic [1:0]       pkt_pos;
  logic [7:0]       hdr_byte;
  logic [7:0]       dx_raw;
  logic [7:0]       dy_raw;
  logic [POS_W-1:0] acc_x;
  logic [POS_W-1:0] acc_y;
  logic [31:0]      wheel_acc;
  buttons_t         btn_state;

  report_t expected_reports[$];

  int  errors = 0;
  int  bytes_sent = 0;
  int  resyncs_sent = 0;
  int  reports_checked = 0;
  int  drops_seen = 0;
  int  long_hold = 0;
  bit  src_burst = 1'b0;
  bit  sink_burst = 1'b0;

  function automatic plan_row_t plan_row(input logic [7:0] d, input logic rs,
                                         input bit typed = 1'b0,
                                         input int x = 0, input int y = 0,
                                         input int s = 0,
                                         input logic [4:0] btn = 5'b00000,
                                         input logic drop = 1'b0);
    plan_row_t r;
    r.data_byte    = d;
    r.resync       = rs;
    r.typed        = typed;
    r.want.pos_x   = x;
    r.want.pos_y   = y;
    r.want.scroll  = s;
    r.want.buttons = buttons_t'(btn);
    r.want.dropped = drop;
    return r;
  endfunction

  // Advance the model by one byte; done is set when the byte closes a packet.
  task automatic advance_decoder(input logic [7:0] d, input logic rs,
                                 output bit done, output report_t r);
    logic [1:0] slot;
    logic       drop;
    slot = rs ? IDX_STATUS : pkt_pos;
    done = 1'b0;
    case (slot)
      IDX_STATUS: begin
        hdr_byte = d;
        pkt_pos  = IDX_DX;
      end
      IDX_DX: begin
        dx_raw  = d;
        pkt_pos = IDX_DY;
      end
      IDX_DY: begin
        dy_raw  = d;
        pkt_pos = IDX_WHEEL;
      end
      default: begin
        pkt_pos = IDX_STATUS;
        drop    = |(hdr_byte & OVF_MASK);
        if (!drop) begin
          acc_x = acc_x + {{(POS_W-8){hdr_byte[4]}}, dx_raw};
          acc_y = acc_y + {{(POS_W-8){hdr_byte[5]}}, dy_raw};
          btn_state.left      = hdr_byte[0];
          btn_state.right     = hdr_byte[1];
          btn_state.middle    = hdr_byte[2];
          btn_state.extra_one = d[4];
          btn_state.extra_two = d[5];
          if (d[3:0] == WHEEL_DOWN) begin
            wheel_acc = wheel_acc - 32'd1;
          end else if (d[3:0] == WHEEL_UP) begin
            wheel_acc = wheel_acc + 32'd1;
          end
        end
        r.pos_x   = OUT_WIDTH'(signed'(acc_x));
        r.pos_y   = OUT_WIDTH'(signed'(acc_y));
        r.scroll  = wheel_acc;
        r.buttons = btn_state;
        r.dropped = drop;
        done      = 1'b1;
      end
    endcase
  endtask

  // Offer one byte, hold it until the transaction, then queue what it yields.
  task automatic send_byte(input logic [7:0] d, input logic rs,
                           input bit typed, input report_t typed_rpt);
    int      gap;
    bit      done;
    report_t got;
    gap = src_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      rx_byte.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_byte.valid     <= 1'b1;
    rx_byte.data_byte <= d;
    rx_byte.resync    <= rs;
    do @(posedge clk); while (!rx_byte.ready);
    advance_decoder(d, rs, done, got);
    if (done) begin
      if (typed) begin
        expected_reports.push_back(typed_rpt);
      end else begin
        expected_reports.push_back(got);
      end
    end
    bytes_sent++;
    if (rs) resyncs_sent++;
  endtask

  task automatic cmp_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Report sink: check each transaction, then stall for a drawn number of cycles.
  initial begin : report_sink
    int      wait_left;
    report_t want;
    report.ready = 1'b0;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && report.valid && report.ready) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected report, expected none, actual pos_x %0d pos_y %0d",
                   $time, report.pos_x, report.pos_y);
        end else begin
          want = expected_reports.pop_front();
          cmp_field("pos_x", want.pos_x, report.pos_x);
          cmp_field("pos_y", want.pos_y, report.pos_y);
          cmp_field("scroll_count", want.scroll, report.scroll_count);
          cmp_field("left_pressed", want.buttons.left, report.left_pressed);
          cmp_field("middle_pressed", want.buttons.middle, report.middle_pressed);
          cmp_field("right_pressed", want.buttons.right, report.right_pressed);
          cmp_field("extra_one_pressed", want.buttons.extra_one, report.extra_one_pressed);
          cmp_field("extra_two_pressed", want.buttons.extra_two, report.extra_two_pressed);
          cmp_field("packet_dropped", want.dropped, report.packet_dropped);
          if (want.dropped) drops_seen++;
        end
        reports_checked++;
        if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
        wait_left = sink_burst ? 0 : $urandom_range(0, 8);
      end
      if (long_hold > 0) begin
        long_hold--;
        report.ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        report.ready <= 1'b0;
      end else begin
        report.ready <= 1'b1;
      end
    end
  end

  // End the run if no transaction happens on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((rx_byte.valid && rx_byte.ready) || (report.valid && report.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    plan_row_t  plan[$];
    plan_row_t  blank_row;
    report_t    blank;
    logic [7:0] pkt_bytes[4];
    logic [3:0] nib;
    int         pkt;
    int         keep;
    int         kind;
    int         directed_bytes;
    bit         need_resync;

    rst               = 1'b1;
    rx_byte.valid     = 1'b0;
    rx_byte.data_byte = 8'h00;
    rx_byte.resync    = 1'b0;
    pkt_pos   = IDX_STATUS;
    hdr_byte  = '0;
    dx_raw    = '0;
    dy_raw    = '0;
    acc_x     = '0;
    acc_y     = '0;
    wheel_acc = '0;
    btn_state = '0;
    blank_row = plan_row(8'h00, 1'b0);
    blank     = blank_row.want;

    // All-zero packet right after reset
    plan.push_back(plan_row(8'h08, 1'b0));
    plan.push_back(plan_row(8'h00, 1'b0));
    plan.push_back(plan_row(8'h00, 1'b0));
    plan.push_back(plan_row(8'h00, 1'b0, 1'b1, 0, 0, 0, 5'b00000, 1'b0));
    // Largest positive deltas, all buttons, wheel up
    plan.push_back(plan_row(8'h0F, 1'b0));
    plan.push_back(plan_row(8'hFF, 1'b0));
    plan.push_back(plan_row(8'hFF, 1'b0));
    plan.push_back(plan_row(8'h31, 1'b0, 1'b1, 255, 255, 1, 5'b11111, 1'b0));
    // Most negative deltas, buttons released, wheel down
    plan.push_back(plan_row(8'h38, 1'b0));
    plan.push_back(plan_row(8'h00, 1'b0));
    plan.push_back(plan_row(8'h00, 1'b0));
    plan.push_back(plan_row(8'h0F, 1'b0, 1'b1, -1, -1, 0, 5'b00000, 1'b0));
    // Abandon a partial packet, then a Y overflow packet
    plan.push_back(plan_row(8'h09, 1'b0));
    plan.push_back(plan_row(8'h10, 1'b0));
    plan.push_back(plan_row(8'h88, 1'b1));
    plan.push_back(plan_row(8'h7F, 1'b0));
    plan.push_back(plan_row(8'h7F, 1'b0));
    plan.push_back(plan_row(8'h3F, 1'b0, 1'b1, -1, -1, 0, 5'b00000, 1'b1));
    // Resync lands where the wheel byte would be; then an X overflow packet
    plan.push_back(plan_row(8'h0B, 1'b0));
    plan.push_back(plan_row(8'h01, 1'b0));
    plan.push_back(plan_row(8'h02, 1'b0));
    plan.push_back(plan_row(8'h48, 1'b1));
    plan.push_back(plan_row(8'h7F, 1'b0));
    plan.push_back(plan_row(8'h81, 1'b0));
    plan.push_back(plan_row(8'h3F, 1'b0, 1'b1, -1, -1, 0, 5'b00000, 1'b1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_byte(plan[i].data_byte, plan[i].resync, plan[i].typed, plan[i].want);
    end
    directed_bytes = bytes_sent;

    pkt = 0;
    need_resync = 1'b0;
    while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
      pkt++;
      if ($urandom_range(0, 7) == 0) src_burst = !src_burst;
      // Starve the output so the block backs up on its input
      if (pkt == 60) long_hold = LONG_HOLD;
      // Let the output drain completely before going on
      if (pkt == 150) begin
        rx_byte.valid <= 1'b0;
        wait (expected_reports.size() == 0);
        @(posedge clk);
      end
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        repeat ($urandom_range(1, 5)) begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, blank);
        end
        need_resync = 1'b1;
      end
      pkt_bytes[0] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 4) != 0) pkt_bytes[0][7:6] = 2'b00;
      pkt_bytes[1] = 8'($urandom_range(0, 255));
      pkt_bytes[2] = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0:       nib = WHEEL_UP;
        1:       nib = WHEEL_DOWN;
        2:       nib = 4'd0;
        default: nib = 4'($urandom_range(0, 15));
      endcase
      pkt_bytes[3] = {4'($urandom_range(0, 15)), nib};
      keep = (kind == 1) ? $urandom_range(1, 3) : 4;
      for (int k = 0; k < keep; k++) begin
        send_byte(pkt_bytes[k],
                  (k == 0) && (need_resync || ($urandom_range(0, 3) == 0)),
                  1'b0, blank);
      end
      need_resync = (keep < 4);
    end

    rx_byte.valid <= 1'b0;
    wait (expected_reports.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes (%0d from the directed table) with %0d resyncs.",
             bytes_sent, directed_bytes, resyncs_sent);
    $display("Checked %0d reports, %0d of them dropped for overflow; %0d errors.",
             reports_checked, drops_seen, errors);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule : testbench
